[hw/rtl/mpp_pkg.sv]
// Shared types, constants and helpers for the Manhattan path plotter.
`timescale 1ns / 1ps
`default_nettype none
package mpp_pkg;

  // Coordinate field width and the number of rows it can address
  localparam int COORD_W   = 6;
  localparam int ROW_LIMIT = 1 << COORD_W;
  // Width of the row_bits result field
  localparam int ROW_BITS_W = 64;

  // Request kinds
  localparam logic REQ_WAYPOINT = 1'b0;
  localparam logic REQ_ROW      = 1'b1;

  // Command from the sequencer to the row store
  typedef struct packed {
    logic                  en;    // issue an access this cycle
    logic                  wr;    // OR the mask into the row; else plain read
    logic [COORD_W-1:0]    row;
    logic [ROW_BITS_W-1:0] mask;
  } mpp_cmd_t;

  // Columns strictly after start up to and including stop, in either direction
  function automatic logic [ROW_BITS_W-1:0] run_mask(logic [COORD_W-1:0] start,
                                                     logic [COORD_W-1:0] stop);
    logic [COORD_W-1:0]    lo;
    logic [COORD_W-1:0]    hi;
    logic [ROW_BITS_W-1:0] m;
    lo = (start < stop) ? start : stop;
    hi = (start < stop) ? stop : start;
    m  = ({ROW_BITS_W{1'b1}} << lo) &
         ({ROW_BITS_W{1'b1}} >> (COORD_W'(ROW_BITS_W - 1) - hi));
    m[start] = 1'b0;
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mpp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mpp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mpp_row_store.sv]
// Grid row store: RAM with per-row valid bits and a pipelined read-OR-write path.
`timescale 1ns / 1ps
`default_nettype none
module mpp_row_store
  import mpp_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int ROWS   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mpp_cmd_t          cmd,
  output logic      [GRID_W-1:0] rdata
);

  localparam int RAW = $clog2(ROWS);

  logic [ROWS-1:0]   row_valid;
  logic              pend_wr;
  logic [RAW-1:0]    pend_row;
  logic [GRID_W-1:0] pend_mask;
  logic [GRID_W-1:0] ram_q;

  mpp_ram #(
    .WIDTH(GRID_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (pend_wr),
    .waddr(pend_row),
    .wdata(rdata | pend_mask),
    .re   (cmd.en),
    .raddr(cmd.row[RAW-1:0]),
    .rdata(ram_q)
  );

  // A row never written reads as clear
  assign rdata = row_valid[pend_row] ? ram_q : '0;

  // Hold the access that is waiting on read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_wr <= 1'b0;
    end else begin
      pend_wr <= cmd.en & cmd.wr;
    end
    if (cmd.en) begin
      pend_row  <= cmd.row[RAW-1:0];
      pend_mask <= cmd.mask[GRID_W-1:0];
    end
  end

  // Mark rows as valid once written back
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (pend_wr) begin
      row_valid[pend_row] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/manhattan_path_plotter.sv]
// Top level of the Manhattan path plotter: request sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// The grid lives in one RAM of min(GRID_H, 64) rows, GRID_W bits each, behind a
// read-modify-write pipeline that takes one row per cycle. A waypoint ORs the whole
// x run into the current row in one access, then walks y one row per cycle, and the
// next request is taken once the walk is done and its result is posted. A row read
// issues its access, then waits for the registered read data. Waypoint coordinates
// beyond the grid saturate to its last column or row; a row read beyond the grid
// returns zero. Every request yields one result carrying the current maxima; the
// result register lets the next request start while a result waits to be taken.
// Reset clears the grid at once through per-row valid bits, with no clearing pass.
module manhattan_path_plotter
  import mpp_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  req_type,
  input  wire logic [COORD_W-1:0]    coord_x,
  input  wire logic [COORD_W-1:0]    coord_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [ROW_BITS_W-1:0] row_bits,
  output logic      [COORD_W-1:0]    max_col,
  output logic      [COORD_W-1:0]    max_row
);

  localparam int                 ROWS   = (GRID_H < ROW_LIMIT) ? GRID_H : ROW_LIMIT;
  localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_W - 1);
  localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YRUN,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_WAIT
  } state_t;

  state_t             state;
  mpp_cmd_t           cmd;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] cur_y;
  logic               started;
  logic [COORD_W-1:0] peak_col;
  logic [COORD_W-1:0] peak_row;
  logic               rd_zero;
  logic [GRID_W-1:0]  store_rdata;

  logic               accept;
  logic               out_free;
  logic               post;
  logic [COORD_W-1:0] tx;
  logic [COORD_W-1:0] ty;
  logic [COORD_W-1:0] cur_y_next;

  mpp_row_store #(
    .GRID_W(GRID_W),
    .ROWS  (ROWS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rdata(store_rdata)
  );

  // Handshake and saturated target
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid & in_ready;
  assign out_free   = ~out_valid | out_ready;
  assign post       = out_free & ((state == ST_DRAIN) | (state == ST_RD_WAIT));
  assign tx         = (coord_x > X_LAST) ? X_LAST : coord_x;
  assign ty         = (coord_y > Y_LAST) ? Y_LAST : coord_y;
  assign cur_y_next = (cur_y < pos_y) ? cur_y + 1'b1 : cur_y - 1'b1;

  // Sequencer, position, maxima and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmd.en    <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      started   <= 1'b0;
      peak_col  <= '0;
      peak_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !post) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cmd.en <= accept;
          if (accept) begin
            if (req_type == REQ_WAYPOINT) begin
              // Plot the x run in the row we start from, or mark the first cell
              cmd.wr   <= 1'b1;
              cmd.row  <= started ? pos_y : ty;
              cmd.mask <= started ? run_mask(pos_x, tx) : (ROW_BITS_W'(1) << tx);
              cur_y    <= started ? pos_y : ty;
              pos_x    <= tx;
              pos_y    <= ty;
              started  <= 1'b1;
              if (tx > peak_col) begin
                peak_col <= tx;
              end
              if (ty > peak_row) begin
                peak_row <= ty;
              end
              state <= ST_YRUN;
            end else begin
              cmd.wr  <= 1'b0;
              cmd.row <= coord_y;
              rd_zero <= (coord_y > Y_LAST);
              state   <= ST_RD_ISSUE;
            end
          end
        end
        ST_YRUN: begin
          // Advance one row per cycle toward the target row
          if (cur_y != pos_y) begin
            cur_y    <= cur_y_next;
            cmd.en   <= 1'b1;
            cmd.wr   <= 1'b1;
            cmd.row  <= cur_y_next;
            cmd.mask <= ROW_BITS_W'(1) << pos_x;
          end else begin
            cmd.en <= 1'b0;
            state  <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Last write-back lands this cycle; post the result
          cmd.en <= 1'b0;
          if (out_free) begin
            out_valid <= 1'b1;
            row_bits  <= '0;
            max_col   <= peak_col;
            max_row   <= peak_row;
            state     <= ST_IDLE;
          end
        end
        ST_RD_ISSUE: begin
          cmd.en <= 1'b0;
          state  <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          cmd.en <= 1'b0;
          if (out_free) begin
            out_valid <= 1'b1;
            row_bits  <= rd_zero ? '0 : ROW_BITS_W'(store_rdata);
            max_col   <= peak_col;
            max_row   <= peak_row;
            state     <= ST_IDLE;
          end
        end
        default: begin
          cmd.en <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Back-to-back store accesses never hit the same row (no read-write overlap)
  a_no_row_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.en && $past(cmd.en) |-> cmd.row != $past(cmd.row))
    else $error("row store accessed the same row in consecutive cycles");

  // A new request is taken only with no store access in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.en)
    else $error("request accepted while a row access is in flight");

  // Maxima never decrease
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> peak_col >= $past(peak_col) && peak_row >= $past(peak_row))
    else $error("tracked maximum decreased");

  // Position stays inside the grid
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos_x <= X_LAST && pos_y <= Y_LAST)
    else $error("position left the grid");
`endif

endmodule
`default_nettype wire

[sim/mpp_checker.sv]
// Checker for the Manhattan path plotter: grid model, expected result queue and compare.
`timescale 1ns / 1ps
module mpp_checker
  import mpp_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  req_type,
  input  wire logic [COORD_W-1:0]    coord_x,
  input  wire logic [COORD_W-1:0]    coord_y,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [ROW_BITS_W-1:0] row_bits,
  input  wire logic [COORD_W-1:0]    max_col,
  input  wire logic [COORD_W-1:0]    max_row,
  output int                         mismatch_count,
  output int                         outstanding
);

  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic [COORD_W-1:0]    max_col;
    logic [COORD_W-1:0]    max_row;
  } row_report_t;

  // Model of the plotter: grid, pen position and peaks
  logic [ROW_BITS_W-1:0] cells [ROW_LIMIT];
  logic [COORD_W-1:0]    pen_x;
  logic [COORD_W-1:0]    pen_y;
  logic                  pen_down;
  logic [COORD_W-1:0]    peak_col;
  logic [COORD_W-1:0]    peak_row;

  // Expected results, oldest first
  row_report_t report_q[$];

  // Set one cell and raise the peaks; cells off the grid are dropped
  function automatic void set_cell(input logic [COORD_W-1:0] cx,
                                   input logic [COORD_W-1:0] cy);
    if (cx < GRID_W && cy < GRID_H) begin
      cells[cy][cx] = 1'b1;
      if (cx > peak_col) peak_col = cx;
      if (cy > peak_row) peak_row = cy;
    end
  endfunction

  // Apply one request to the model and return the result it produces
  function automatic row_report_t plot_request(input logic                kind,
                                               input logic [COORD_W-1:0] tx,
                                               input logic [COORD_W-1:0] ty);
    row_report_t res;
    res.row_bits = '0;
    if (kind == REQ_WAYPOINT) begin
      // Clamp the target into the grid
      if (tx > GRID_W - 1) tx = COORD_W'(GRID_W - 1);
      if (ty > GRID_H - 1) ty = COORD_W'(GRID_H - 1);
      if (!pen_down) begin
        set_cell(tx, ty);
        pen_down = 1'b1;
      end else begin
        // Walk along x first, then along y, marking every cell entered
        while (pen_x != tx) begin
          pen_x = (pen_x < tx) ? pen_x + 1'b1 : pen_x - 1'b1;
          set_cell(pen_x, pen_y);
        end
        while (pen_y != ty) begin
          pen_y = (pen_y < ty) ? pen_y + 1'b1 : pen_y - 1'b1;
          set_cell(pen_x, pen_y);
        end
      end
      pen_x = tx;
      pen_y = ty;
    end else if (ty < GRID_H) begin
      res.row_bits = cells[ty];
    end
    res.max_col = peak_col;
    res.max_row = peak_row;
    return res;
  endfunction

  // Print the first few bad results, count them all
  function automatic void flag_result(input string what, input row_report_t exp_r);
    if (mismatch_count < 10) begin
      $display("[%0t] %s: expected %h col %0d row %0d, got %h col %0d row %0d",
               $time, what, exp_r.row_bits, exp_r.max_col, exp_r.max_row,
               row_bits, max_col, max_row);
    end
    mismatch_count++;
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin : watch
    row_report_t exp_r;
    if (rst) begin
      for (int r = 0; r < ROW_LIMIT; r++) cells[r] = '0;
      pen_x          = '0;
      pen_y          = '0;
      pen_down       = 1'b0;
      peak_col       = '0;
      peak_row       = '0;
      mismatch_count = 0;
      report_q.delete();
    end else begin
      // Predict each accepted request transaction
      if (in_valid && in_ready) begin
        report_q.push_back(plot_request(req_type, coord_x, coord_y));
      end
      // Compare each accepted result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          exp_r = '0;
          flag_result("unexpected result", exp_r);
        end else begin
          exp_r = report_q.pop_front();
          if (row_bits !== exp_r.row_bits || max_col !== exp_r.max_col ||
              max_row !== exp_r.max_row) begin
            flag_result("result mismatch", exp_r);
          end
        end
      end
    end
    outstanding = report_q.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the Manhattan path plotter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import mpp_pkg::*;

  localparam int GRID_W      = 64;
  localparam int GRID_H      = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 460;
  localparam int DRAIN_WAIT  = 70;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  req_type  = REQ_WAYPOINT;
  logic [COORD_W-1:0]    coord_x   = '0;
  logic [COORD_W-1:0]    coord_y   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_BITS_W-1:0] row_bits;
  logic [COORD_W-1:0]    max_col;
  logic [COORD_W-1:0]    max_row;

  int mismatch_count;
  int outstanding;
  int send_idle   = 0;
  int recv_stall  = 0;
  int cycle_count = 0;
  int last_x      = 0;
  int last_y      = 0;

  manhattan_path_plotter #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_bits (row_bits),
    .max_col  (max_col),
    .max_row  (max_row)
  );

  mpp_checker #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .row_bits      (row_bits),
    .max_col       (max_col),
    .max_row       (max_row),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  always #6 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one request transaction; entered and left at a falling edge
  task automatic send_request(input logic kind, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    coord_x  <= x;
    coord_y  <= y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (kind == REQ_WAYPOINT) begin
      last_x = x;
      last_y = y;
    end
  endtask

  // Pick a random request: mostly waypoints, half of them short hops
  task automatic send_random;
    int nx;
    int ny;
    if ($urandom_range(99) < 40) begin
      send_request(REQ_ROW, COORD_W'($urandom), COORD_W'($urandom));
    end else if ($urandom_range(1) == 1) begin
      nx = last_x + int'($urandom_range(6)) - 3;
      ny = last_y + int'($urandom_range(6)) - 3;
      nx = (nx < 0) ? 0 : (nx > 63) ? 63 : nx;
      ny = (ny < 0) ? 0 : (ny > 63) ? 63 : ny;
      send_request(REQ_WAYPOINT, COORD_W'(nx), COORD_W'(ny));
    end else begin
      send_request(REQ_WAYPOINT, COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reads on a clear grid, first waypoint, corners, repeats
    send_request(REQ_ROW, 6'd0, 6'd0);
    send_request(REQ_ROW, 6'd63, 6'd63);
    send_request(REQ_WAYPOINT, 6'd5, 6'd7);
    send_request(REQ_ROW, 6'd0, 6'd7);
    send_request(REQ_WAYPOINT, 6'd5, 6'd7);
    send_request(REQ_WAYPOINT, 6'd63, 6'd7);
    send_request(REQ_WAYPOINT, 6'd63, 6'd63);
    send_request(REQ_WAYPOINT, 6'd63, 6'd63);
    send_request(REQ_WAYPOINT, 6'd0, 6'd63);
    send_request(REQ_WAYPOINT, 6'd0, 6'd0);
    send_request(REQ_WAYPOINT, 6'd63, 6'd0);
    send_request(REQ_ROW, 6'd42, 6'd0);
    send_request(REQ_ROW, 6'd63, 6'd7);
    send_request(REQ_ROW, 6'd21, 6'd63);
    send_request(REQ_ROW, 6'd0, 6'd31);
    send_request(REQ_WAYPOINT, 6'd32, 6'd33);
    send_request(REQ_WAYPOINT, 6'd31, 6'd32);
    send_request(REQ_ROW, 6'd0, 6'd33);
    send_request(REQ_ROW, 6'd0, 6'd32);
    send_request(REQ_ROW, 6'd0, 6'd62);

    // Random: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end
    in_valid <= 1'b0;

    // Drain, then allow for stray results
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
